// ----- design/hts_pkg.sv -----
// ----------------------------------------------------------------------------
// hts_pkg
// Shared widths, register indexes, default gains and saturation helpers for
// the Holt trend smoothing forecaster.
// ----------------------------------------------------------------------------
package hts_pkg;

    localparam int LVL_W  = 40;
    localparam int TRD_W  = 41;
    localparam int OPD_W  = 44;
    localparam int HALF_W = 22;
    localparam int PRD_W  = 40;
    localparam int ACC_W  = 61;
    localparam int RND_W  = ACC_W - 16;
    localparam int FACC_W = 48;
    localparam int GAIN_W = 16;
    localparam int STEP_W = 7;
    localparam int IDX_W  = 2;
    localparam int CNT_W  = 2;

    localparam logic [IDX_W-1:0] REG_LEVEL_GAIN = 2'd0;
    localparam logic [IDX_W-1:0] REG_TREND_GAIN = 2'd1;
    localparam logic [IDX_W-1:0] REG_HORIZON    = 2'd2;

    localparam logic [GAIN_W-1:0] DEF_LEVEL_GAIN = 16'd19661;
    localparam logic [GAIN_W-1:0] DEF_TREND_GAIN = 16'd6554;
    localparam logic [STEP_W-1:0] DEF_HORIZON    = 7'd8;

    localparam logic [CNT_W-1:0] MIN_SAMPLES = 2'd3;

    localparam logic signed [FACC_W-1:0] LVL_MAX = 48'sh007F_FFFF_FFFF;
    localparam logic signed [FACC_W-1:0] LVL_MIN = -LVL_MAX - 48'sd1;
    localparam logic signed [FACC_W-1:0] TRD_MAX = 48'sh00FF_FFFF_FFFF;
    localparam logic signed [FACC_W-1:0] TRD_MIN = -TRD_MAX - 48'sd1;

    typedef struct packed {
        logic lo;
        logic hi;
    } t_mac_ctl;

    function automatic logic signed [LVL_W-1:0] sat_lvl(input logic signed [FACC_W-1:0] v);
        logic signed [LVL_W-1:0] r;
        if (v > LVL_MAX) begin
            r = LVL_MAX[LVL_W-1:0];
        end else if (v < LVL_MIN) begin
            r = LVL_MIN[LVL_W-1:0];
        end else begin
            r = v[LVL_W-1:0];
        end
        return r;
    endfunction

    function automatic logic signed [TRD_W-1:0] sat_trd(input logic signed [FACC_W-1:0] v);
        logic signed [TRD_W-1:0] r;
        if (v > TRD_MAX) begin
            r = TRD_MAX[TRD_W-1:0];
        end else if (v < TRD_MIN) begin
            r = TRD_MIN[TRD_W-1:0];
        end else begin
            r = v[TRD_W-1:0];
        end
        return r;
    endfunction

endpackage

// ----- design/hts_if.sv -----
// ----------------------------------------------------------------------------
// hts_if
// Valid/ready channels of the forecaster: sample input, forecast output and
// configuration writes.
// ----------------------------------------------------------------------------
interface hts_in_if #(
    parameter int SAMPLE_BITS = 24
) ();
    logic                   valid;
    logic                   ready;
    logic [SAMPLE_BITS-1:0] sample;
    logic                   last_sample;

    modport source(output valid, sample, last_sample, input ready);
    modport sink(input valid, sample, last_sample, output ready);
endinterface

interface hts_out_if import hts_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic signed [LVL_W-1:0] forecast_value;
    logic [STEP_W-1:0]       step_ahead;
    logic                    too_few;
    logic                    last_result;

    modport source(output valid, forecast_value, step_ahead, too_few, last_result,
                   input ready);
    modport sink(input valid, forecast_value, step_ahead, too_few, last_result,
                 output ready);
endinterface

interface hts_cfg_if import hts_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [IDX_W-1:0]  index;
    logic [GAIN_W-1:0] data;

    modport source(output valid, index, data, input ready);
    modport sink(input valid, index, data, output ready);
endinterface

// ----- design/hts_mac.sv -----
// ----------------------------------------------------------------------------
// hts_mac
// Shared gain multiplier: a 44 bit operand times a 16 bit gain in two halves,
// accumulated with half-up rounding; the result is the product over 2^16.
// ----------------------------------------------------------------------------
module hts_mac import hts_pkg::*; (
    input  logic                    i_clk,
    input  t_mac_ctl                i_ctl,
    input  logic signed [OPD_W-1:0] i_opd,
    input  logic [GAIN_W-1:0]       i_gain,
    output logic signed [RND_W-1:0] o_rnd
);

    logic signed [HALF_W:0]   w_a;
    logic signed [GAIN_W:0]   w_b;
    logic signed [PRD_W-1:0]  w_prod;
    logic signed [ACC_W-1:0]  w_prod_x;
    logic signed [ACC_W-1:0]  r_acc;
    logic signed [ACC_W-1:0]  n_acc;

    assign w_a      = i_ctl.lo ? $signed({1'b0, i_opd[HALF_W-1:0]})
                               : $signed({i_opd[OPD_W-1], i_opd[OPD_W-1:HALF_W]});
    assign w_b      = $signed({1'b0, i_gain});
    assign w_prod   = w_a * w_b;
    assign w_prod_x = ACC_W'(w_prod);

    always_comb begin
        n_acc = r_acc;
        if (i_ctl.lo) begin
            n_acc = w_prod_x;
        end else if (i_ctl.hi) begin
            n_acc = r_acc + (w_prod_x <<< HALF_W) + ACC_W'(32768);
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc <= n_acc;
    end

    assign o_rnd = r_acc[ACC_W-1:16];

endmodule

// ----- design/holt_trend_smoothing_forecaster_unit.sv -----
// ----------------------------------------------------------------------------
// holt_trend_smoothing_forecaster_unit
// Holt double exponential smoothing over Q16.8 demand samples with Q0.16
// gains; emits level + k*trend forecasts at the end of each series.
// ----------------------------------------------------------------------------
// One sample is taken at a time, and ready is low until the block returns to
// IDLE. The first two samples of a series pass through LOAD and END only; every
// later sample also walks MLO, MHI, LVL, TDIF, MLO, MHI and TRD, as the four
// dependent half products (two per gain) go through the single 23x17 multiplier.
// On the last sample the block then emits horizon forecasts (or one too_few
// result for series under three samples) at one item per cycle while the sink
// is ready, through a registered output, built by repeated addition of the
// trend. Configuration writes are always accepted and take effect on the next
// cycle, so a write while a sample is in flight changes the gains or horizon
// that sample uses; write them only between samples.
module holt_trend_smoothing_forecaster_unit import hts_pkg::*; #(
    parameter int MAX_HORIZON = 64,
    parameter int SAMPLE_BITS = 24
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    hts_in_if.sink       i_in,
    hts_out_if.source    o_out,
    hts_cfg_if.sink      i_cfg
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_LOAD  = 4'd1;
    localparam logic [3:0] S_MLO   = 4'd2;
    localparam logic [3:0] S_MHI   = 4'd3;
    localparam logic [3:0] S_LVL   = 4'd4;
    localparam logic [3:0] S_TDIF  = 4'd5;
    localparam logic [3:0] S_TRD   = 4'd6;
    localparam logic [3:0] S_END   = 4'd7;
    localparam logic [3:0] S_EMIT  = 4'd8;

    localparam logic [STEP_W-1:0] MAX_H = STEP_W'(MAX_HORIZON);

    logic [3:0]              r_state, n_state;
    logic [GAIN_W-1:0]       r_level_gain, r_trend_gain;
    logic [STEP_W-1:0]       r_horizon;
    logic [SAMPLE_BITS-1:0]  r_x, r_first;
    logic                    r_last;
    logic [CNT_W-1:0]        r_seen, n_seen;
    logic signed [LVL_W-1:0] r_level, n_level, r_lvn, n_lvn;
    logic signed [TRD_W-1:0] r_trend, n_trend;
    logic [SAMPLE_BITS-1:0]  n_first;
    logic signed [OPD_W-1:0] r_opd, n_opd;
    logic                    r_phase, n_phase;
    logic signed [FACC_W-1:0] r_facc, n_facc;
    logic [STEP_W-1:0]       r_k, n_k, r_n, n_n;

    logic                    r_out_valid, n_out_valid;
    logic signed [LVL_W-1:0] r_out_fc, n_out_fc;
    logic [STEP_W-1:0]       r_out_step, n_out_step;
    logic                    r_out_few, n_out_few;
    logic                    r_out_last, n_out_last;

    t_mac_ctl                w_ctl;
    logic [GAIN_W-1:0]       w_gain;
    logic signed [RND_W-1:0] w_rnd;
    logic                    w_in_acc;
    logic                    w_out_free;
    logic signed [FACC_W-1:0] w_level_x, w_trend_x, w_pred, w_x;
    logic [STEP_W-1:0]       w_hclamp;

    assign i_in.ready  = (r_state == S_IDLE);
    assign i_cfg.ready = 1'b1;
    assign w_in_acc    = i_in.valid && i_in.ready;
    assign w_out_free  = !r_out_valid || o_out.ready;

    assign w_level_x = FACC_W'(r_level);
    assign w_trend_x = FACC_W'(r_trend);
    assign w_pred    = w_level_x + w_trend_x;
    assign w_x       = $signed({{(FACC_W-SAMPLE_BITS){1'b0}}, r_x});

    always_comb begin
        if (r_phase) begin
            w_gain = (r_trend_gain != '0) ? r_trend_gain : DEF_TREND_GAIN;
        end else begin
            w_gain = (r_level_gain != '0) ? r_level_gain : DEF_LEVEL_GAIN;
        end
        if (r_horizon == '0) begin
            w_hclamp = STEP_W'(1);
        end else if (r_horizon > MAX_H) begin
            w_hclamp = MAX_H;
        end else begin
            w_hclamp = r_horizon;
        end
    end

    assign w_ctl.lo = (r_state == S_MLO);
    assign w_ctl.hi = (r_state == S_MHI);

    hts_mac u_mac (
        .i_clk  (i_clk),
        .i_ctl  (w_ctl),
        .i_opd  (r_opd),
        .i_gain (w_gain),
        .o_rnd  (w_rnd)
    );

    always_comb begin
        n_state     = r_state;
        n_seen      = r_seen;
        n_level     = r_level;
        n_trend     = r_trend;
        n_first     = r_first;
        n_lvn       = r_lvn;
        n_opd       = r_opd;
        n_phase     = r_phase;
        n_facc      = r_facc;
        n_k         = r_k;
        n_n         = r_n;
        n_out_valid = r_out_valid && !o_out.ready;
        n_out_fc    = r_out_fc;
        n_out_step  = r_out_step;
        n_out_few   = r_out_few;
        n_out_last  = r_out_last;
        case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    n_state = S_LOAD;
                end
            end
            S_LOAD: begin
                n_state = S_END;
                if (r_seen != MIN_SAMPLES) begin
                    n_seen = r_seen + CNT_W'(1);
                end
                if (r_seen == '0) begin
                    n_first = r_x;
                    n_level = LVL_W'(w_x);
                    n_trend = '0;
                end else if (r_seen == CNT_W'(1)) begin
                    n_trend = TRD_W'(w_x - $signed({{(FACC_W-SAMPLE_BITS){1'b0}}, r_first}));
                    n_level = LVL_W'(w_x);
                end else begin
                    n_opd   = OPD_W'(w_x - w_pred);
                    n_phase = 1'b0;
                    n_state = S_MLO;
                end
            end
            S_MLO: begin
                n_state = S_MHI;
            end
            S_MHI: begin
                n_state = r_phase ? S_TRD : S_LVL;
            end
            S_LVL: begin
                n_lvn   = sat_lvl(w_pred + FACC_W'(w_rnd));
                n_state = S_TDIF;
            end
            S_TDIF: begin
                n_opd   = OPD_W'(FACC_W'(r_lvn) - w_level_x - w_trend_x);
                n_level = r_lvn;
                n_phase = 1'b1;
                n_state = S_MLO;
            end
            S_TRD: begin
                n_trend = sat_trd(w_trend_x + FACC_W'(w_rnd));
                n_state = S_END;
            end
            S_END: begin
                if (!r_last) begin
                    n_state = S_IDLE;
                end else if (r_seen != MIN_SAMPLES) begin
                    if (w_out_free) begin
                        n_out_valid = 1'b1;
                        n_out_fc    = '0;
                        n_out_step  = '0;
                        n_out_few   = 1'b1;
                        n_out_last  = 1'b1;
                        n_seen      = '0;
                        n_level     = '0;
                        n_trend     = '0;
                        n_first     = '0;
                        n_state     = S_IDLE;
                    end
                end else begin
                    n_facc  = w_pred;
                    n_k     = STEP_W'(1);
                    n_n     = w_hclamp;
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_out_fc    = sat_lvl(r_facc);
                    n_out_step  = r_k;
                    n_out_few   = 1'b0;
                    n_out_last  = (r_k == r_n);
                    n_facc      = r_facc + w_trend_x;
                    n_k         = r_k + STEP_W'(1);
                    if (r_k == r_n) begin
                        n_seen  = '0;
                        n_level = '0;
                        n_trend = '0;
                        n_first = '0;
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_seen       <= '0;
            r_level      <= '0;
            r_trend      <= '0;
            r_first      <= '0;
            r_out_valid  <= 1'b0;
            r_level_gain <= DEF_LEVEL_GAIN;
            r_trend_gain <= DEF_TREND_GAIN;
            r_horizon    <= DEF_HORIZON;
        end else begin
            r_state     <= n_state;
            r_seen      <= n_seen;
            r_level     <= n_level;
            r_trend     <= n_trend;
            r_first     <= n_first;
            r_out_valid <= n_out_valid;
            if (i_cfg.valid) begin
                case (i_cfg.index)
                    REG_LEVEL_GAIN: r_level_gain <= i_cfg.data;
                    REG_TREND_GAIN: r_trend_gain <= i_cfg.data;
                    REG_HORIZON:    r_horizon    <= i_cfg.data[STEP_W-1:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_x    <= i_in.sample[SAMPLE_BITS-1:0];
            r_last <= i_in.last_sample;
        end
        r_lvn      <= n_lvn;
        r_opd      <= n_opd;
        r_phase    <= n_phase;
        r_facc     <= n_facc;
        r_k        <= n_k;
        r_n        <= n_n;
        r_out_fc   <= n_out_fc;
        r_out_step <= n_out_step;
        r_out_few  <= n_out_few;
        r_out_last <= n_out_last;
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.forecast_value = r_out_fc;
    assign o_out.step_ahead     = r_out_step;
    assign o_out.too_few        = r_out_few;
    assign o_out.last_result    = r_out_last;

endmodule

// ----- design/hts_checker.sv -----
// ----------------------------------------------------------------------------
// hts_checker
// Port-level checks on the forecaster: busy after a sample, result shapes and
// back-to-back forecast delivery.
// ----------------------------------------------------------------------------
module hts_checker import hts_pkg::*; (
    input logic                    clk,
    input logic                    rst_n,
    input logic                    in_valid,
    input logic                    in_ready,
    input logic                    out_valid,
    input logic                    out_ready,
    input logic signed [LVL_W-1:0] out_fc,
    input logic [STEP_W-1:0]       out_step,
    input logic                    out_few,
    input logic                    out_last
);

    a_busy_after_item: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("ready high right after an item");

    a_error_shape: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_few) |-> (out_fc == '0 && out_step == '0 && out_last))
        else $error("malformed too_few result");

    a_step_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_few) |-> (out_step != '0))
        else $error("forecast with zero step");

    a_run_continues: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && !out_last) |=> out_valid)
        else $error("gap inside a forecast run");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(out_fc) && $stable(out_step)))
        else $error("stalled result changed");

endmodule

bind holt_trend_smoothing_forecaster_unit hts_checker u_hts_checker (
    .clk       (i_clk),
    .rst_n     (i_rst_n),
    .in_valid  (i_in.valid),
    .in_ready  (i_in.ready),
    .out_valid (o_out.valid),
    .out_ready (o_out.ready),
    .out_fc    (o_out.forecast_value),
    .out_step  (o_out.step_ahead),
    .out_few   (o_out.too_few),
    .out_last  (o_out.last_result)
);
